/* src/vfvl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package vfvl_pkg;

    localparam int CFG_GAIN_W = 16;
    localparam int CFG_VEL_W  = 15;
    localparam int FRAC_W     = 16;
    localparam int TURN_W     = 16;
    localparam int APB_AW     = 5;
    localparam int APB_DW     = 32;
    localparam int OUT_DW     = 32;
    localparam int OUT_UW     = 2;

    localparam logic [2:0] REG_ANGULAR_GAIN    = 3'd0;
    localparam logic [2:0] REG_TURN_DEADBAND   = 3'd1;
    localparam logic [2:0] REG_TURN_LIMIT      = 3'd2;
    localparam logic [2:0] REG_TARGET_FRACTION = 3'd3;
    localparam logic [2:0] REG_MIN_FRACTION    = 3'd4;
    localparam logic [2:0] REG_DISTANCE_GAIN   = 3'd5;
    localparam logic [2:0] REG_MAX_FORWARD     = 3'd6;
    localparam logic [2:0] REG_MIN_FORWARD     = 3'd7;

    localparam logic [CFG_GAIN_W-1:0] RST_ANGULAR_GAIN    = 16'd256;
    localparam logic [CFG_VEL_W-1:0]  RST_TURN_DEADBAND   = 15'd205;
    localparam logic [CFG_VEL_W-1:0]  RST_TURN_LIMIT      = 15'd4096;
    localparam logic [FRAC_W-1:0]     RST_TARGET_FRACTION = 16'd19661;
    localparam logic [FRAC_W-1:0]     RST_MIN_FRACTION    = 16'd3277;
    localparam logic [CFG_GAIN_W-1:0] RST_DISTANCE_GAIN   = 16'd512;
    localparam logic [CFG_VEL_W-1:0]  RST_MAX_FORWARD     = 15'd2048;
    localparam logic [CFG_VEL_W-1:0]  RST_MIN_FORWARD     = 15'd410;

    typedef struct packed {
        logic [CFG_GAIN_W-1:0] angular_gain;
        logic [CFG_VEL_W-1:0]  turn_deadband;
        logic [CFG_VEL_W-1:0]  turn_limit;
        logic [FRAC_W-1:0]     target_fraction;
        logic [FRAC_W-1:0]     min_fraction;
        logic [CFG_GAIN_W-1:0] distance_gain;
        logic [CFG_VEL_W-1:0]  max_forward;
        logic [CFG_VEL_W-1:0]  min_forward;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_FLAG,
        ST_MUL,
        ST_CLAMP,
        ST_SCALE,
        ST_SWAIT,
        ST_DONE
    } t_back_state;

endpackage

`default_nettype wire

/* src/vfvl_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module vfvl_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_wr_valid,
    output logic              o_wr_ready,
    input  wire logic [W-1:0] i_wr_data,
    output logic              o_rd_valid,
    input  wire logic         i_rd_ready,
    output logic [W-1:0]      o_rd_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_wr_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_rd_valid = (r_cnt != '0);
    assign o_rd_data  = r_mem[r_rd];
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

/* src/vfvl_div.sv */
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle
module vfvl_div #(
    parameter int N_W = 30,
    parameter int D_W = 16,
    parameter int Q_W = 15
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [N_W-1:0] i_num,
    input  wire logic [D_W-1:0] i_den,
    output logic                o_busy,
    output logic                o_ovf,
    output logic [Q_W-1:0]      o_quo
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [N_W+D_W-1:0] w_wide;
    logic [D_W:0]       w_trial;
    logic               w_ge;
    logic [D_W-1:0]     r_rem;
    logic [D_W-1:0]     r_den;
    logic [Q_W-1:0]     r_sh;
    logic               r_ovf;
    logic               r_busy;
    logic [CNT_W-1:0]   r_cnt;

    assign w_wide  = (N_W + D_W)'(i_num);
    assign w_trial = {r_rem, r_sh[Q_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign o_busy  = r_busy;
    assign o_ovf   = r_ovf;
    assign o_quo   = r_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(Q_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= w_wide[Q_W +: D_W];
            r_sh  <= i_num[Q_W-1:0];
            r_den <= i_den;
            r_ovf <= ((w_wide >> Q_W) >= (N_W + D_W)'(i_den));
        end else if (r_busy) begin
            r_rem <= w_ge ? D_W'(w_trial - {1'b0, r_den}) : w_trial[D_W-1:0];
            r_sh  <= {r_sh[Q_W-2:0], w_ge};
        end
    end

endmodule

`default_nettype wire

/* src/vfvl_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module vfvl_front
    import vfvl_pkg::*;
#(
    parameter int PIXEL_BITS = 12
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_s_valid,
    output logic                           o_s_ready,
    input  wire logic [PIXEL_BITS:0]       i_box_left,
    input  wire logic [PIXEL_BITS-1:0]     i_box_width,
    input  wire logic [PIXEL_BITS-1:0]     i_box_height,
    input  wire logic [PIXEL_BITS-1:0]     i_image_width,
    input  wire logic [PIXEL_BITS-1:0]     i_image_height,
    input  wire logic [CFG_GAIN_W-1:0]     i_angular_gain,
    output logic                           o_q_valid,
    input  wire logic                      i_q_ready,
    output logic                           o_neg,
    output logic [CFG_GAIN_W+PIXEL_BITS:0] o_gm,
    output logic [PIXEL_BITS-1:0]          o_iw,
    output logic [2*PIXEL_BITS-1:0]        o_area,
    output logic [2*PIXEL_BITS-1:0]        o_aden
);

    localparam int P    = PIXEL_BITS;
    localparam int GM_W = CFG_GAIN_W + P + 1;

    logic [P+1:0]   w_off;
    logic [P:0]     w_mag;
    logic           w_a_ready;
    logic           w_b_ready;

    logic           r_a_vld;
    logic           r_a_neg;
    logic [P:0]     r_a_mag;
    logic [P-1:0]   r_a_bw;
    logic [P-1:0]   r_a_bh;
    logic [P-1:0]   r_a_iw;
    logic [P-1:0]   r_a_ih;

    logic           r_b_vld;
    logic           r_b_neg;
    logic [GM_W-1:0] r_b_gm;
    logic [P-1:0]   r_b_iw;
    logic [2*P-1:0] r_b_area;
    logic [2*P-1:0] r_b_aden;

    // horizontal offset of box center from image center
    assign w_off = {3'b000, i_image_width[P-1:1]}
                 - ({i_box_left[P], i_box_left} + {3'b000, i_box_width[P-1:1]});
    assign w_mag = w_off[P+1] ? (P + 1)'(-w_off) : w_off[P:0];

    assign w_b_ready = !r_b_vld || i_q_ready;
    assign w_a_ready = !r_a_vld || w_b_ready;
    assign o_s_ready = w_a_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (w_a_ready) begin
                r_a_vld <= i_s_valid;
            end
            if (w_b_ready) begin
                r_b_vld <= r_a_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_ready && i_s_valid) begin
            r_a_neg <= w_off[P+1];
            r_a_mag <= w_mag;
            r_a_bw  <= i_box_width;
            r_a_bh  <= i_box_height;
            r_a_iw  <= (i_image_width == '0) ? P'(1) : i_image_width;
            r_a_ih  <= (i_image_height == '0) ? P'(1) : i_image_height;
        end
        if (w_b_ready && r_a_vld) begin
            r_b_neg  <= r_a_neg;
            r_b_gm   <= GM_W'(i_angular_gain) * GM_W'(r_a_mag);
            r_b_iw   <= r_a_iw;
            r_b_area <= (2 * P)'(r_a_bw) * (2 * P)'(r_a_bh);
            r_b_aden <= (2 * P)'(r_a_iw) * (2 * P)'(r_a_ih);
        end
    end

    assign o_q_valid = r_b_vld;
    assign o_neg     = r_b_neg;
    assign o_gm      = r_b_gm;
    assign o_iw      = r_b_iw;
    assign o_area    = r_b_area;
    assign o_aden    = r_b_aden;

endmodule

`default_nettype wire

/* src/vfvl_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module vfvl_back
    import vfvl_pkg::*;
#(
    parameter int PIXEL_BITS    = 12,
    parameter int VEL_FRAC_BITS = 12
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_cfg                      i_cfg,
    input  wire logic                      i_q_valid,
    output logic                           o_q_ready,
    input  wire logic                      i_neg,
    input  wire logic [CFG_GAIN_W+PIXEL_BITS:0] i_gm,
    input  wire logic [PIXEL_BITS-1:0]     i_iw,
    input  wire logic [2*PIXEL_BITS-1:0]   i_area,
    input  wire logic [2*PIXEL_BITS-1:0]   i_aden,
    output logic                           o_m_valid,
    input  wire logic                      i_m_ready,
    output logic [OUT_DW-1:0]              o_m_data,
    output logic [OUT_UW-1:0]              o_m_user
);

    localparam int P      = PIXEL_BITS;
    localparam int GM_W   = CFG_GAIN_W + P + 1;
    localparam int TN_W   = GM_W + VEL_FRAC_BITS - 8;
    localparam int FN_W   = 2 * P + FRAC_W;
    localparam int FQ_W   = FRAC_W + 1;
    localparam int PROD_W = 2 * CFG_GAIN_W;
    localparam int SH     = 24 - VEL_FRAC_BITS;
    localparam int VR_W   = PROD_W - SH;
    localparam int SN_W   = 2 * CFG_VEL_W;
    localparam int SD_W   = CFG_VEL_W + 1;
    localparam logic [FQ_W-1:0] FRAC_ONE = FQ_W'(1) << FRAC_W;

    t_back_state r_state;
    t_back_state n_state;

    logic                 w_div_start;
    logic                 w_scale_start;
    logic                 w_out_load;

    logic [TN_W-1:0]      w_tnum;
    logic                 w_t_busy;
    logic                 w_t_ovf;
    logic [CFG_VEL_W-1:0] w_t_quo;
    logic                 w_f_busy;
    logic                 w_f_ovf;
    logic [FQ_W-1:0]      w_f_quo;
    logic                 w_s_busy;
    logic                 w_s_ovf;
    logic [CFG_VEL_W-1:0] w_s_quo;
    logic [VR_W-1:0]      w_vraw;
    logic [CFG_VEL_W-1:0] w_speed;
    logic [TURN_W-1:0]    w_turn;

    logic                 r_neg;
    logic [CFG_VEL_W-1:0] r_tmag;
    logic [FQ_W-1:0]      r_frac;
    logic                 r_reached;
    logic                 r_small;
    logic [FRAC_W-1:0]    r_diff;
    logic [PROD_W-1:0]    r_prod;
    logic [CFG_VEL_W-1:0] r_v;
    logic                 r_out_vld;
    logic [OUT_DW-1:0]    r_out_data;
    logic [OUT_UW-1:0]    r_out_user;

    assign w_tnum = TN_W'(i_gm) << (VEL_FRAC_BITS - 8);

    vfvl_div #(.N_W(TN_W), .D_W(P), .Q_W(CFG_VEL_W)) u_turn_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_tnum),
        .i_den   (i_iw),
        .o_busy  (w_t_busy),
        .o_ovf   (w_t_ovf),
        .o_quo   (w_t_quo)
    );

    vfvl_div #(.N_W(FN_W), .D_W(2 * P), .Q_W(FQ_W)) u_frac_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   ({i_area, FRAC_W'(0)}),
        .i_den   (i_aden),
        .o_busy  (w_f_busy),
        .o_ovf   (w_f_ovf),
        .o_quo   (w_f_quo)
    );

    // quotient stays at or below v/2 because |turn| never exceeds the limit
    vfvl_div #(.N_W(SN_W), .D_W(SD_W), .Q_W(CFG_VEL_W)) u_scale_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_scale_start),
        .i_num   (SN_W'(r_v) * SN_W'(r_tmag)),
        .i_den   ({i_cfg.turn_limit, 1'b0}),
        .o_busy  (w_s_busy),
        .o_ovf   (w_s_ovf),
        .o_quo   (w_s_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_q_ready     = 1'b0;
        w_div_start   = 1'b0;
        w_scale_start = 1'b0;
        w_out_load    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_q_ready = 1'b1;
                if (i_q_valid) begin
                    w_div_start = 1'b1;
                    n_state     = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!w_t_busy && !w_f_busy) begin
                    n_state = ST_FLAG;
                end
            end
            ST_FLAG:  n_state = ST_MUL;
            ST_MUL:   n_state = ST_CLAMP;
            ST_CLAMP: n_state = ST_SCALE;
            ST_SCALE: begin
                w_scale_start = 1'b1;
                n_state       = ST_SWAIT;
            end
            ST_SWAIT: begin
                if (!w_s_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_vld || i_m_ready) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign w_vraw = VR_W'(r_prod >> SH);

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_neg <= i_neg;
            end
            ST_DIV: begin
                if (w_t_ovf) begin
                    r_tmag <= i_cfg.turn_limit;
                end else if (w_t_quo < i_cfg.turn_deadband) begin
                    r_tmag <= '0;
                end else if (w_t_quo > i_cfg.turn_limit) begin
                    r_tmag <= i_cfg.turn_limit;
                end else begin
                    r_tmag <= w_t_quo;
                end
                r_frac <= (w_f_ovf || (w_f_quo > FRAC_ONE)) ? FRAC_ONE : w_f_quo;
            end
            ST_FLAG: begin
                r_reached <= (r_frac >= FQ_W'(i_cfg.target_fraction));
                r_small   <= (r_frac < FQ_W'(i_cfg.min_fraction));
                r_diff    <= i_cfg.target_fraction - r_frac[FRAC_W-1:0];
            end
            ST_MUL: begin
                r_prod <= PROD_W'(i_cfg.distance_gain) * PROD_W'(r_diff);
            end
            ST_CLAMP: begin
                if (w_vraw > VR_W'(i_cfg.max_forward)) begin
                    r_v <= i_cfg.max_forward;
                end else if (w_vraw < VR_W'(i_cfg.min_forward)) begin
                    r_v <= i_cfg.min_forward;
                end else begin
                    r_v <= w_vraw[CFG_VEL_W-1:0];
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        if (r_reached || r_small) begin
            w_speed = '0;
        end else if (i_cfg.turn_limit == '0) begin
            w_speed = r_v;
        end else begin
            w_speed = r_v - w_s_quo;
        end
        w_turn = r_neg ? TURN_W'(-{1'b0, r_tmag}) : {1'b0, r_tmag};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_m_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= OUT_DW'({w_speed, w_turn});
            r_out_user <= {r_small, r_reached};
        end
    end

    assign o_m_valid = r_out_vld;
    assign o_m_data  = r_out_data;
    assign o_m_user  = r_out_user;

endmodule

`default_nettype wire

/* src/visual_follow_velocity_law_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Visual follow velocity law: each input beat carries a tracked box and the frame
// size, and one output beat returns the turn rate and forward speed with the
// target-reached and box-too-small flags. The front end takes a beat every cycle
// unless back-pressure stalls it, and registers the offset and then the products;
// a two-entry queue feeds the back end, which handles one item at a time, as set
// by its sequencer: a 17-step area-fraction divider (the 15-step turn divider runs
// beside it), four steps, then a 15-step speed-scaling divider. A finished result
// waits in the output register while the next item is worked on.
module visual_follow_velocity_law_top
    import vfvl_pkg::*;
#(
    parameter int PIXEL_BITS    = 12,
    parameter int VEL_FRAC_BITS = 12
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // box_left, box_width, box_height, image_width, image_height
    input  wire logic [((5*PIXEL_BITS+8)/8)*8-1:0] i_s_axis_tdata,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // turn_rate, forward_speed
    output logic [OUT_DW-1:0]           o_m_axis_tdata,
    // target_reached, box_too_small
    output logic [OUT_UW-1:0]           o_m_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_AW-1:0]      paddr,
    input  wire logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]           prdata,
    output logic                        pready
);

    localparam int P     = PIXEL_BITS;
    localparam int GM_W  = CFG_GAIN_W + P + 1;
    localparam int JOB_W = 1 + GM_W + P + 4 * P;

    t_cfg             r_cfg;
    logic             w_front_vld;
    logic             w_front_rdy;
    logic             w_front_neg;
    logic [GM_W-1:0]  w_front_gm;
    logic [P-1:0]     w_front_iw;
    logic [2*P-1:0]   w_front_area;
    logic [2*P-1:0]   w_front_aden;
    logic             w_job_vld;
    logic             w_job_rdy;
    logic [JOB_W-1:0] w_job;

    // config port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.angular_gain    <= RST_ANGULAR_GAIN;
            r_cfg.turn_deadband   <= RST_TURN_DEADBAND;
            r_cfg.turn_limit      <= RST_TURN_LIMIT;
            r_cfg.target_fraction <= RST_TARGET_FRACTION;
            r_cfg.min_fraction    <= RST_MIN_FRACTION;
            r_cfg.distance_gain   <= RST_DISTANCE_GAIN;
            r_cfg.max_forward     <= RST_MAX_FORWARD;
            r_cfg.min_forward     <= RST_MIN_FORWARD;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[4:2])
                REG_ANGULAR_GAIN:    r_cfg.angular_gain    <= pwdata[CFG_GAIN_W-1:0];
                REG_TURN_DEADBAND:   r_cfg.turn_deadband   <= pwdata[CFG_VEL_W-1:0];
                REG_TURN_LIMIT:      r_cfg.turn_limit      <= pwdata[CFG_VEL_W-1:0];
                REG_TARGET_FRACTION: r_cfg.target_fraction <= pwdata[FRAC_W-1:0];
                REG_MIN_FRACTION:    r_cfg.min_fraction    <= pwdata[FRAC_W-1:0];
                REG_DISTANCE_GAIN:   r_cfg.distance_gain   <= pwdata[CFG_GAIN_W-1:0];
                REG_MAX_FORWARD:     r_cfg.max_forward     <= pwdata[CFG_VEL_W-1:0];
                REG_MIN_FORWARD:     r_cfg.min_forward     <= pwdata[CFG_VEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_ANGULAR_GAIN:    prdata = APB_DW'(r_cfg.angular_gain);
            REG_TURN_DEADBAND:   prdata = APB_DW'(r_cfg.turn_deadband);
            REG_TURN_LIMIT:      prdata = APB_DW'(r_cfg.turn_limit);
            REG_TARGET_FRACTION: prdata = APB_DW'(r_cfg.target_fraction);
            REG_MIN_FRACTION:    prdata = APB_DW'(r_cfg.min_fraction);
            REG_DISTANCE_GAIN:   prdata = APB_DW'(r_cfg.distance_gain);
            REG_MAX_FORWARD:     prdata = APB_DW'(r_cfg.max_forward);
            REG_MIN_FORWARD:     prdata = APB_DW'(r_cfg.min_forward);
            default:             prdata = '0;
        endcase
    end

    vfvl_front #(.PIXEL_BITS(P)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_valid      (i_s_axis_tvalid),
        .o_s_ready      (o_s_axis_tready),
        .i_box_left     (i_s_axis_tdata[P:0]),
        .i_box_width    (i_s_axis_tdata[2*P:P+1]),
        .i_box_height   (i_s_axis_tdata[3*P:2*P+1]),
        .i_image_width  (i_s_axis_tdata[4*P:3*P+1]),
        .i_image_height (i_s_axis_tdata[5*P:4*P+1]),
        .i_angular_gain (r_cfg.angular_gain),
        .o_q_valid      (w_front_vld),
        .i_q_ready      (w_front_rdy),
        .o_neg          (w_front_neg),
        .o_gm           (w_front_gm),
        .o_iw           (w_front_iw),
        .o_area         (w_front_area),
        .o_aden         (w_front_aden)
    );

    vfvl_fifo #(.W(JOB_W), .DEPTH(2)) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_front_vld),
        .o_wr_ready (w_front_rdy),
        .i_wr_data  ({w_front_neg, w_front_gm, w_front_iw, w_front_area, w_front_aden}),
        .o_rd_valid (w_job_vld),
        .i_rd_ready (w_job_rdy),
        .o_rd_data  (w_job)
    );

    vfvl_back #(.PIXEL_BITS(P), .VEL_FRAC_BITS(VEL_FRAC_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_job_vld),
        .o_q_ready (w_job_rdy),
        .i_neg     (w_job[JOB_W-1]),
        .i_gm      (w_job[JOB_W-2 -: GM_W]),
        .i_iw      (w_job[4*P +: P]),
        .i_area    (w_job[2*P +: 2*P]),
        .i_aden    (w_job[0 +: 2*P]),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_m_data  (o_m_axis_tdata),
        .o_m_user  (o_m_axis_tuser)
    );

`ifndef SYNTHESIS
    logic [TURN_W-1:0] a_turn_abs;
    assign a_turn_abs = o_m_axis_tdata[TURN_W-1] ? TURN_W'(-o_m_axis_tdata[TURN_W-1:0])
                                                 : o_m_axis_tdata[TURN_W-1:0];

    a_turn_within_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (a_turn_abs <= {1'b0, r_cfg.turn_limit}))
        else $error("turn rate exceeds turn limit");

    a_flag_stops_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser != '0)) |->
        (o_m_axis_tdata[TURN_W +: CFG_VEL_W] == '0))
        else $error("nonzero speed with a flag set");

    a_speed_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
        ((o_m_axis_tdata[TURN_W +: CFG_VEL_W] <= r_cfg.max_forward) ||
         (o_m_axis_tdata[TURN_W +: CFG_VEL_W] <= r_cfg.min_forward)))
        else $error("forward speed above clamp");
`endif

endmodule

`default_nettype wire
